@@ rtl/core/rasr_pkg.sv @@
// Shared types and constants for the real-time clock alarm and status registers.
// Holds the request and response item layouts, register indexes and status bits.
// No dependencies.
package rasr_pkg;

    // Kinds of request carried on the input channel.
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_kind_t;

    // Word indexes within the register window.
    localparam logic [9:0] IDX_SECONDS = 10'd0;
    localparam logic [9:0] IDX_ALARM   = 10'd1;
    localparam logic [9:0] IDX_STATUS  = 10'd2;
    localparam logic [9:0] IDX_TRIM    = 10'd3;

    // Status byte layout.
    localparam int unsigned ALARM_FLAG_BIT = 0;
    localparam int unsigned HZ_FLAG_BIT    = 1;
    localparam int unsigned ALARM_EN_BIT   = 2;
    localparam int unsigned HZ_EN_BIT      = 3;
    localparam logic [7:0]  FLAG_MASK      = 8'h03;

    // Trim register.
    localparam int unsigned TRIM_LOCK_BIT = 31;
    localparam logic [31:0] TRIM_RESET    = 32'h0000_7FFF;

    // Channel widths.
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 40;

    // One request as held in the input register.
    typedef struct packed {
        req_kind_t   req_type;
        logic [9:0]  reg_index;
        logic        access_is_word;
        logic [31:0] write_data;
        logic [31:0] now_seconds;
    } req_t;

    // One response as held in the result register.
    typedef struct packed {
        logic [31:0] read_data;
        logic        access_ok;
        logic        alarm_irq;
        logic        hz_irq;
    } rsp_t;

endpackage

@@ rtl/core/rtc_alarm_status_registers.sv @@
// Top level of the real-time clock alarm and status register block.
// Instantiates rasr_in_reg, rasr_exec and rasr_out_reg; uses rasr_pkg.
//
// Each request (bus read, bus write or one-second tick) is taken into an input
// register, decoded combinationally against the register state, and its response
// is loaded into a result register, from which it is offered, once that register
// has room. One request is accepted every cycle as long as
// responses are taken; the result register is the only point of backpressure,
// and while it holds an untaken response the input stage still takes one more.
// The state updates in request order, so a read sees every earlier write.
module rtc_alarm_status_registers
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // req_type
    input  logic [79:0] s_axis_tdata,   // reg_index, access_is_word, write_data,
                                        // now_seconds, zero padding
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data, access_ok, alarm_irq, hz_irq,
                                        // zero padding
);

    logic           out_free;
    logic           in_valid;
    logic           fire;
    rasr_pkg::req_t req;
    rasr_pkg::rsp_t rsp;

    // A request executes when it is held and the result register has room.
    assign fire = in_valid && out_free;

    rasr_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .out_free      (out_free),
        .valid         (in_valid),
        .req           (req)
    );

    rasr_exec u_exec
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req),
        .rsp   (rsp)
    );

    rasr_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .rsp           (rsp),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/core/rasr_in_reg.sv @@
// Input register stage of the real-time clock register block.
// Takes one input request per cycle when not stalled; uses rasr_pkg.
module rasr_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [1:0]          s_axis_tuser,
    input  logic [79:0]         s_axis_tdata,
    input  logic                out_free,
    output logic                valid,
    output rasr_pkg::req_t      req
);

    logic           valid_reg;
    logic           valid_next;
    rasr_pkg::req_t req_reg;

    // A held request moves on whenever the result register has room.
    assign s_axis_tready = !valid_reg || out_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Request payload, unpacked from the stream fields.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            req_reg.req_type       <= rasr_pkg::req_kind_t'(s_axis_tuser);
            req_reg.reg_index      <= s_axis_tdata[9:0];
            req_reg.access_is_word <= s_axis_tdata[10];
            req_reg.write_data     <= s_axis_tdata[42:11];
            req_reg.now_seconds    <= s_axis_tdata[74:43];
        end
    end

    assign valid = valid_reg;
    assign req   = req_reg;

endmodule

@@ rtl/core/rasr_exec.sv @@
// Register state and request decode of the real-time clock register block.
// Holds alarm, status, trim and last-check registers; uses rasr_pkg.
module rasr_exec
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  rasr_pkg::req_t      req,
    output rasr_pkg::rsp_t      rsp
);

    logic [31:0] alarm_reg;
    logic [31:0] alarm_next;
    logic [7:0]  status_reg;
    logic [7:0]  status_next;
    logic [31:0] trim_reg;
    logic [31:0] trim_next;
    logic [31:0] last_reg;
    logic [31:0] last_next;
    logic [31:0] read_data;
    logic        access_ok;

    // Decode one request against the current state.
    always_comb
    begin
        logic [31:0] now_dec;
        now_dec     = req.now_seconds - 32'd1;
        alarm_next  = alarm_reg;
        status_next = status_reg;
        trim_next   = trim_reg;
        last_next   = last_reg;
        read_data   = 32'd0;
        access_ok   = 1'b1;
        unique case (req.req_type)
            rasr_pkg::REQ_READ:
            begin
                if (!req.access_is_word)
                begin
                    access_ok = 1'b0;
                end
                else
                begin
                    unique case (req.reg_index)
                        rasr_pkg::IDX_SECONDS: read_data = req.now_seconds;
                        rasr_pkg::IDX_ALARM:   read_data = alarm_reg;
                        rasr_pkg::IDX_STATUS:  read_data = {24'd0, status_reg};
                        rasr_pkg::IDX_TRIM:    read_data = trim_reg;
                        default:               read_data = 32'd0;
                    endcase
                end
            end
            rasr_pkg::REQ_WRITE:
            begin
                if (!req.access_is_word)
                begin
                    access_ok = 1'b0;
                end
                else
                begin
                    unique case (req.reg_index)
                        rasr_pkg::IDX_ALARM:
                        begin
                            // Rearm: the check runs as if last done one second ago.
                            alarm_next = req.write_data;
                            if (now_dec < req.write_data)
                            begin
                                if (status_reg[rasr_pkg::ALARM_EN_BIT] &&
                                    (req.now_seconds >= req.write_data))
                                begin
                                    status_next[rasr_pkg::ALARM_FLAG_BIT] = 1'b1;
                                end
                                last_next = req.now_seconds;
                            end
                            else
                            begin
                                last_next = now_dec;
                            end
                        end
                        rasr_pkg::IDX_STATUS:
                        begin
                            // Flags clear on a written one; the rest is plain storage.
                            status_next = (req.write_data[7:0] & ~rasr_pkg::FLAG_MASK) |
                                          (status_reg & ~req.write_data[7:0] &
                                           rasr_pkg::FLAG_MASK);
                        end
                        rasr_pkg::IDX_TRIM:
                        begin
                            if (!trim_reg[rasr_pkg::TRIM_LOCK_BIT])
                            begin
                                trim_next = req.write_data;
                            end
                        end
                        default:
                        begin
                            alarm_next = alarm_reg;
                        end
                    endcase
                end
            end
            rasr_pkg::REQ_TICK:
            begin
                // Alarm compare first, then the one-hertz flag.
                if (last_reg < alarm_reg)
                begin
                    if (status_reg[rasr_pkg::ALARM_EN_BIT] &&
                        (req.now_seconds >= alarm_reg))
                    begin
                        status_next[rasr_pkg::ALARM_FLAG_BIT] = 1'b1;
                    end
                    last_next = req.now_seconds;
                end
                if (status_reg[rasr_pkg::HZ_EN_BIT])
                begin
                    status_next[rasr_pkg::HZ_FLAG_BIT] = 1'b1;
                end
            end
            default:
            begin
                read_data = 32'd0;
            end
        endcase
    end

    // State registers advance only when the request moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg  <= 32'd0;
            status_reg <= 8'd0;
            trim_reg   <= rasr_pkg::TRIM_RESET;
            last_reg   <= 32'd0;
        end
        else if (fire)
        begin
            alarm_reg  <= alarm_next;
            status_reg <= status_next;
            trim_reg   <= trim_next;
            last_reg   <= last_next;
        end
    end

    assign rsp.read_data = read_data;
    assign rsp.access_ok = access_ok;
    assign rsp.alarm_irq = status_next[rasr_pkg::ALARM_FLAG_BIT];
    assign rsp.hz_irq    = status_next[rasr_pkg::HZ_FLAG_BIT];

endmodule

@@ rtl/core/rasr_out_reg.sv @@
// Result register of the real-time clock register block.
// Holds one response until the output channel takes it; uses rasr_pkg.
module rasr_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  rasr_pkg::rsp_t      rsp,
    output logic                out_free,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata
);

    logic           valid_reg;
    logic           valid_next;
    rasr_pkg::rsp_t rsp_reg;

    // Room for a new response when empty or being drained this cycle.
    assign out_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {5'd0, rsp_reg.hz_irq, rsp_reg.alarm_irq,
                            rsp_reg.access_ok, rsp_reg.read_data};

endmodule

@@ rtl/core/rasr_checker.sv @@
// Port-level checks for the real-time clock alarm and status register block.
// Bound to rtc_alarm_status_registers; needs no package.
module rasr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic [79:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // The input side only stalls when a response is waiting on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no response pending");

    // A failed access never returns read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("failed access returned data");

    // A stalled response stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("response dropped while stalled");

    // A stalled response holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("response changed while stalled");

endmodule

bind rtc_alarm_status_registers rasr_checker u_rasr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ sim/rtc_alarm_status_registers_checker.sv @@
// Response checker for the real-time clock alarm and status register block.
// Predicts each response from the accepted requests and compares it with the block.
// Depends on rasr_pkg for request kinds, register indexes and status bit positions.
`timescale 1ns / 100ps

module rtc_alarm_status_registers_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // req_type
    input  logic [79:0] s_axis_tdata,   // reg_index, access_is_word, write_data,
                                        // now_seconds, zero padding
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // read_data, access_ok, alarm_irq, hz_irq,
                                        // zero padding
    output int          mismatches,
    output int          outstanding
);

    // Shadow copy of the register state.
    logic [31:0] alarm_q;
    logic [7:0]  status_q;
    logic [31:0] trim_q;
    logic [31:0] last_check_q;

    // Responses still owed by the block, oldest first.
    rasr_pkg::rsp_t owed_responses[$];
    rasr_pkg::rsp_t want_rsp;
    rasr_pkg::rsp_t seen_rsp;

    // Alarm compare: only armed while the last check lies before the alarm time.
    function automatic void evaluate_alarm(input logic [31:0] now);
        if (last_check_q < alarm_q)
        begin
            if (status_q[rasr_pkg::ALARM_EN_BIT] && now >= alarm_q)
                status_q[rasr_pkg::ALARM_FLAG_BIT] = 1'b1;
            last_check_q = now;
        end
    endfunction

    // Applies one request to the shadow state and returns the response it causes.
    function automatic rasr_pkg::rsp_t predict_response(input rasr_pkg::req_kind_t kind,
                                                        input logic [9:0] idx,
                                                        input logic is_word,
                                                        input logic [31:0] data,
                                                        input logic [31:0] now);
        rasr_pkg::rsp_t r;
        r = '0;
        r.access_ok = 1'b1;
        case (kind)
            rasr_pkg::REQ_READ, rasr_pkg::REQ_WRITE:
            begin
                if (!is_word)
                    r.access_ok = 1'b0;
                else if (kind == rasr_pkg::REQ_READ)
                begin
                    case (idx)
                        rasr_pkg::IDX_SECONDS: r.read_data = now;
                        rasr_pkg::IDX_ALARM:   r.read_data = alarm_q;
                        rasr_pkg::IDX_STATUS:  r.read_data = {24'd0, status_q};
                        rasr_pkg::IDX_TRIM:    r.read_data = trim_q;
                        default:               r.read_data = '0;
                    endcase
                end
                else
                begin
                    case (idx)
                        rasr_pkg::IDX_ALARM:
                        begin
                            // Rearm: the check runs as if last done one second ago.
                            alarm_q      = data;
                            last_check_q = now - 32'd1;
                            evaluate_alarm(now);
                        end
                        rasr_pkg::IDX_STATUS:
                            // Flags are write-one-to-clear, the other bits are plain.
                            status_q = (data[7:0] & ~rasr_pkg::FLAG_MASK) |
                                       (status_q & ~data[7:0] & rasr_pkg::FLAG_MASK);
                        rasr_pkg::IDX_TRIM:
                            if (!trim_q[rasr_pkg::TRIM_LOCK_BIT])
                                trim_q = data;
                        default:
                            ;
                    endcase
                end
            end
            rasr_pkg::REQ_TICK:
            begin
                evaluate_alarm(now);
                if (status_q[rasr_pkg::HZ_EN_BIT])
                    status_q[rasr_pkg::HZ_FLAG_BIT] = 1'b1;
            end
            default:
                ;
        endcase
        r.alarm_irq = status_q[rasr_pkg::ALARM_FLAG_BIT];
        r.hz_irq    = status_q[rasr_pkg::HZ_FLAG_BIT];
        return r;
    endfunction

    // Responses are compared before the request of the same edge is predicted,
    // since a request never answers within the cycle it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_q      = '0;
            status_q     = '0;
            trim_q       = rasr_pkg::TRIM_RESET;
            last_check_q = '0;
            owed_responses.delete();
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_rsp.read_data = m_axis_tdata[31:0];
                seen_rsp.access_ok = m_axis_tdata[32];
                seen_rsp.alarm_irq = m_axis_tdata[33];
                seen_rsp.hz_irq    = m_axis_tdata[34];
                if (owed_responses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response with no request outstanding: data=%h",
                                 $realtime, m_axis_tdata);
                end
                else
                begin
                    want_rsp = owed_responses.pop_front();
                    if (want_rsp.read_data !== seen_rsp.read_data ||
                        want_rsp.access_ok !== seen_rsp.access_ok ||
                        want_rsp.alarm_irq !== seen_rsp.alarm_irq ||
                        want_rsp.hz_irq    !== seen_rsp.hz_irq)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected rd=%h ok=%b alarm=%b hz=%b",
                                      " got rd=%h ok=%b alarm=%b hz=%b"},
                                     $realtime, want_rsp.read_data, want_rsp.access_ok,
                                     want_rsp.alarm_irq, want_rsp.hz_irq,
                                     seen_rsp.read_data, seen_rsp.access_ok,
                                     seen_rsp.alarm_irq, seen_rsp.hz_irq);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                owed_responses.push_back(
                    predict_response(rasr_pkg::req_kind_t'(s_axis_tuser),
                                     s_axis_tdata[9:0],
                                     s_axis_tdata[10],
                                     s_axis_tdata[42:11],
                                     s_axis_tdata[74:43]));
            outstanding = owed_responses.size();
        end
    end

endmodule

@@ sim/rtc_alarm_status_registers_tb.sv @@
// Testbench top for the real-time clock alarm and status register block.
// Drives directed and random requests with random gaps and stalls and gives the verdict.
// Depends on rasr_pkg, rtc_alarm_status_registers and rtc_alarm_status_registers_checker.
`timescale 1ns / 100ps

module rtc_alarm_status_registers_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;   // req_type
    logic [79:0] s_axis_tdata;   // reg_index, access_is_word, write_data, now_seconds,
                                 // zero padding
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // read_data, access_ok, alarm_irq, hz_irq, zero padding

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    bit sender_idles = 1'b1;

    always #6 clk = ~clk;

    rtc_alarm_status_registers dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rtc_alarm_status_registers_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Idle cycles before the next request or the next response.
    function automatic int draw_gap(input bit enable);
        return enable ? int'($urandom_range(0, 6)) : 0;
    endfunction

    // Offers one request and holds it until the block takes it.
    task automatic issue_request(input rasr_pkg::req_kind_t kind, input logic [9:0] idx,
                                 input logic is_word, input logic [31:0] data,
                                 input logic [31:0] now);
        int gap;
        gap = draw_gap(sender_idles);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, now, data, is_word, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // The run ends if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Response side: random stalls, calm stretches and two long holds that back up
    // the block while the sender keeps offering requests.
    initial
    begin
        int stall;
        int taken;
        bit receiver_idles;
        taken = 0;
        m_axis_tready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            receiver_idles = !((taken >= 200 && taken < 300) || (taken >= 600 && taken < 650));
            stall = draw_gap(receiver_idles);
            if (taken == 300 || taken == 700)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            taken++;
        end
    end

    // Request side and verdict.
    initial
    begin
        logic [31:0]         clock_now;
        logic [31:0]         data;
        logic [9:0]          idx;
        logic                is_word;
        rasr_pkg::req_kind_t kind;
        int                  pick;

        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= rasr_pkg::REQ_READ;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads of the reset state, the seconds extremes and an unused index.
        issue_request(rasr_pkg::REQ_READ, rasr_pkg::IDX_SECONDS, 1'b1,
                      32'h0000_0000, 32'h0000_0000);
        issue_request(rasr_pkg::REQ_READ, rasr_pkg::IDX_SECONDS, 1'b1,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(rasr_pkg::REQ_READ, rasr_pkg::IDX_ALARM, 1'b1,
                      32'h0000_0000, 32'd1);
        issue_request(rasr_pkg::REQ_READ, rasr_pkg::IDX_STATUS, 1'b1,
                      32'h0000_0000, 32'd1);
        issue_request(rasr_pkg::REQ_READ, rasr_pkg::IDX_TRIM, 1'b1,
                      32'h0000_0000, 32'd1);
        issue_request(rasr_pkg::REQ_READ, 10'h3FF, 1'b1, 32'h0000_0000, 32'd2);

        // Sub-word accesses fail, and ignored writes leave the state alone.
        issue_request(rasr_pkg::REQ_READ, rasr_pkg::IDX_TRIM, 1'b0,
                      32'h0000_0000, 32'd2);
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_STATUS, 1'b0,
                      32'h0000_00FF, 32'd3);
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_SECONDS, 1'b1,
                      32'h0000_1234, 32'd3);
        issue_request(rasr_pkg::REQ_WRITE, 10'h3FF, 1'b1, 32'hFFFF_FFFF, 32'd4);

        // Enable both interrupts, arm the alarm ahead and let a tick reach it.
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_STATUS, 1'b1,
                      32'h0000_000C, 32'd10);
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_ALARM, 1'b1,
                      32'd100, 32'd50);
        issue_request(rasr_pkg::REQ_TICK, rasr_pkg::IDX_SECONDS, 1'b1,
                      32'h0000_0000, 32'd99);
        issue_request(rasr_pkg::REQ_TICK, rasr_pkg::IDX_SECONDS, 1'b0,
                      32'h0000_0000, 32'd100);
        issue_request(rasr_pkg::REQ_READ, rasr_pkg::IDX_STATUS, 1'b1,
                      32'h0000_0000, 32'd100);

        // Clear only the alarm flag; the hz flag stays.
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_STATUS, 1'b1,
                      32'hFFFF_FF0D, 32'd101);

        // Alarm written at the current time fires at once; alarm at zero wraps
        // the last-check time so no check runs; the top of the range fires.
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_ALARM, 1'b1,
                      32'd500, 32'd500);
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_ALARM, 1'b1,
                      32'h0000_0000, 32'h0000_0000);
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_ALARM, 1'b1,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(rasr_pkg::REQ_TICK, rasr_pkg::IDX_SECONDS, 1'b1,
                      32'h0000_0000, 32'd5);

        // Plain upper status bits with both enables off and both flags cleared.
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_STATUS, 1'b1,
                      32'h0000_00F3, 32'd6);

        // Trim takes writes until its lock bit is set.
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_TRIM, 1'b1,
                      32'h1234_5678, 32'd7);
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_TRIM, 1'b1,
                      32'h8000_0000, 32'd8);
        issue_request(rasr_pkg::REQ_WRITE, rasr_pkg::IDX_TRIM, 1'b1,
                      32'h0000_0000, 32'd9);
        issue_request(rasr_pkg::REQ_READ, rasr_pkg::IDX_TRIM, 1'b1,
                      32'h0000_0000, 32'd9);

        // Random traffic around a running seconds count, with ticks advancing it,
        // alarms mostly set close to now and status writes mostly enabling both.
        clock_now = $urandom();
        for (int n = 0; n < 800; n++)
        begin
            sender_idles = !((n >= 100 && n < 200) || (n >= 500 && n < 560));
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 39) == 0)
                clock_now = $urandom();
            else if ($urandom_range(0, 99) == 0)
                clock_now = 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
            is_word = ($urandom_range(0, 15) != 0);
            if ($urandom_range(0, 9) == 0)
                idx = 10'($urandom_range(4, 1023));
            else
                idx = 10'($urandom_range(0, 3));
            data = $urandom();
            if (pick < 30)
            begin
                clock_now = clock_now + 32'd1;
                kind      = rasr_pkg::REQ_TICK;
            end
            else if (pick < 60)
                kind = rasr_pkg::REQ_READ;
            else
            begin
                kind = rasr_pkg::REQ_WRITE;
                if (idx == rasr_pkg::IDX_ALARM && $urandom_range(0, 4) != 0)
                    data = clock_now + 32'($urandom_range(0, 6)) - 32'd1;
                else if (idx == rasr_pkg::IDX_STATUS && $urandom_range(0, 3) != 0)
                    data[rasr_pkg::HZ_EN_BIT:rasr_pkg::ALARM_EN_BIT] = 2'b11;
            end
            issue_request(kind, idx, is_word, data, clock_now);
        end
        s_axis_tvalid <= 1'b0;

        // Drain the owed responses, then leave time for any stray one.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rasr_pkg.sv
rtl/core/rasr_in_reg.sv
rtl/core/rasr_exec.sv
rtl/core/rasr_out_reg.sv
rtl/core/rtc_alarm_status_registers.sv
rtl/core/rasr_checker.sv
sim/rtc_alarm_status_registers_checker.sv
sim/rtc_alarm_status_registers_tb.sv
